// File: rtl/core/rcel_pkg.sv
`default_nettype none

package rcel_pkg;

  // opcodes of an input word
  localparam logic [2:0] OP_INIT   = 3'd0;
  localparam logic [2:0] OP_FREQ   = 3'd1;
  localparam logic [2:0] OP_BINARY = 3'd2;
  localparam logic [2:0] OP_DIRECT = 3'd3;
  localparam logic [2:0] OP_FLUSH  = 3'd4;

  // coder constants
  localparam logic [31:0] TOP_LIMIT    = 32'h0100_0000;
  localparam logic [31:0] LOW_RELEASE  = 32'hFF00_0000;
  localparam logic [31:0] RANGE_INIT   = 32'hFFFF_FFFF;
  localparam logic [31:0] PEND_MAX     = 32'hFFFF_FFFF;
  localparam logic [7:0]  FF_BYTE      = 8'hFF;
  localparam logic [5:0]  RAW_MAX      = 6'd32;
  localparam logic [2:0]  RENORM_MAX   = 3'd4;
  localparam logic [2:0]  FLUSH_LAST   = 3'd4;
  localparam logic [3:0]  MAX_RESULTS  = 4'd10;

  // multiplier operand choice
  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_START_Q,
    MUL_Q_SIZE,
    MUL_TMP_PZ
  } mul_sel_t;

  // commands from controller to datapath
  typedef struct packed {
    logic     load;
    logic     init;
    logic     div_start;
    mul_sel_t mul_sel;
    logic     add_low;
    logic     set_range;
    logic     bin_apply;
    logic     shift_tmp;
    logic     db_step;
    logic     emit;
    logic     emit_second;
    logic     ls_update;
    logic     ls_range;
    logic     fix;
    logic     fin_out;
  } rc_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic div_done;
    logic range_lt_top;
    logic release_byte;
    logic pend_gt1;
    logic res_full;
    logic emit_ok;
    logic held_valid;
    logic cnt_zero;
  } rc_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/rcel_div.sv
`default_nettype none

module rcel_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic [31:0]      quo,
  output logic             done
);

  localparam logic [4:0] LAST_STEP = 5'd31;

  logic [31:0] rem;
  logic [31:0] dvs;
  logic [4:0]  cnt;
  logic        busy;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic        ge;

  // one quotient bit per cycle, restoring; divisor zero gives all ones
  assign rem_sh  = {rem, quo[31]};
  assign rem_sub = rem_sh - {1'b0, dvs};
  assign ge      = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == LAST_STEP) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
      cnt <= '0;
    end else if (busy) begin
      rem <= ge ? rem_sub[31:0] : rem_sh[31:0];
      quo <= {quo[30:0], ge};
      cnt <= cnt + 5'd1;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/rcel_dp.sv
`default_nettype none

module rcel_dp (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire rcel_pkg::rc_cmd_t cmd,
  output rcel_pkg::rc_sts_t   sts,
  input  wire logic [31:0]    freq_start,
  input  wire logic [31:0]    freq_size,
  input  wire logic [31:0]    freq_total,
  input  wire logic [31:0]    prob_zero,
  input  wire logic [4:0]     prob_bits,
  input  wire logic           bit_value,
  input  wire logic [31:0]    raw_value,
  input  wire logic [5:0]     raw_count,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          out_byte,
  output logic [31:0]         repeat_count,
  output logic                last
);

  // coder state
  logic [32:0] low;
  logic [31:0] range;
  logic [7:0]  cache;
  logic [31:0] pending;

  // captured operands
  logic [31:0] fstart;
  logic [31:0] fsize;
  logic [31:0] pzero;
  logic [4:0]  pbits;
  logic        bitv;
  logic [31:0] raw;
  logic [5:0]  cnt;
  logic [31:0] tmp;
  logic [31:0] prod;

  // held result and result count
  logic        hv;
  logic [7:0]  hbyte;
  logic [31:0] hcount;
  logic [3:0]  rcount;

  logic [31:0] quo;
  logic        div_done;
  logic [5:0]  cnt_sat;
  logic [5:0]  raw_sh;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic [31:0] lo32;
  logic        carry;
  logic        rel;
  logic [31:0] range_half;
  logic [7:0]  new_byte;
  logic [31:0] new_count;
  logic        out_free;

  rcel_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (range),
    .divisor  (freq_total),
    .quo      (quo),
    .done     (div_done)
  );

  // operand setup for direct bits
  assign cnt_sat = (raw_count > rcel_pkg::RAW_MAX) ? rcel_pkg::RAW_MAX : raw_count;
  assign raw_sh  = rcel_pkg::RAW_MAX - cnt_sat;

  // shared multiplier, low word kept
  always_comb begin
    case (cmd.mul_sel)
      rcel_pkg::MUL_START_Q: begin mul_a = fstart; mul_b = quo;   end
      rcel_pkg::MUL_Q_SIZE:  begin mul_a = quo;    mul_b = fsize; end
      rcel_pkg::MUL_TMP_PZ:  begin mul_a = tmp;    mul_b = pzero; end
      default:               begin mul_a = '0;     mul_b = '0;    end
    endcase
  end
  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  // low shift decode
  assign lo32       = low[31:0];
  assign carry      = low[32];
  assign rel        = (lo32 < rcel_pkg::LOW_RELEASE) || carry;
  assign range_half = {1'b0, range[31:1]};
  assign new_byte   = cmd.emit_second ? (rcel_pkg::FF_BYTE + {7'd0, carry})
                                      : (cache + {7'd0, carry});
  assign new_count  = cmd.emit_second ? (pending - 32'd1) : 32'd1;
  assign out_free   = !out_valid || out_ready;

  // status
  assign sts.div_done     = div_done;
  assign sts.range_lt_top = range < rcel_pkg::TOP_LIMIT;
  assign sts.release_byte = rel;
  assign sts.pend_gt1     = pending > 32'd1;
  assign sts.res_full     = rcount == rcel_pkg::MAX_RESULTS;
  assign sts.emit_ok      = !hv || out_free;
  assign sts.held_valid   = hv;
  assign sts.cnt_zero     = cnt == 6'd0;

  // operand capture and scratch registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fstart <= freq_start;
      fsize  <= freq_size;
      pzero  <= prob_zero;
      pbits  <= prob_bits;
      bitv   <= bit_value;
      raw    <= raw_value << raw_sh;
      cnt    <= cnt_sat;
    end else if (cmd.db_step) begin
      raw <= {raw[30:0], 1'b0};
      cnt <= cnt - 6'd1;
    end
    if (cmd.shift_tmp) begin
      tmp <= range >> pbits;
    end
    if (cmd.mul_sel != rcel_pkg::MUL_NONE) begin
      prod <= mul_p[31:0];
    end
  end

  // coder state update
  always_ff @(posedge clk) begin
    if (rst || cmd.init) begin
      low     <= '0;
      range   <= rcel_pkg::RANGE_INIT;
      cache   <= '0;
      pending <= 32'd1;
    end else begin
      if (cmd.add_low) begin
        low <= low + {1'b0, prod};
      end
      if (cmd.set_range) begin
        range <= prod;
      end
      if (cmd.bin_apply) begin
        if (bitv) begin
          low   <= low + {1'b0, prod};
          range <= range - prod;
        end else begin
          range <= prod;
        end
      end
      if (cmd.db_step) begin
        range <= range_half;
        if (raw[31]) begin
          low <= low + {1'b0, range_half};
        end
      end
      if (cmd.ls_update) begin
        if (rel) begin
          cache   <= lo32[31:24];
          pending <= 32'd1;
        end else if (pending != rcel_pkg::PEND_MAX) begin
          pending <= pending + 32'd1;
        end
        low <= {1'b0, lo32[23:0], 8'd0};
        if (cmd.ls_range) begin
          range <= {range[23:0], 8'd0};
        end
      end
      if (cmd.fix && range == 32'd0) begin
        range <= rcel_pkg::RANGE_INIT;
      end
    end
  end

  // held result and output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      hv        <= 1'b0;
      out_valid <= 1'b0;
      rcount    <= '0;
    end else begin
      if ((cmd.emit && hv) || cmd.fin_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.load) begin
        rcount <= '0;
      end
      if (cmd.emit) begin
        hv     <= 1'b1;
        rcount <= rcount + 4'd1;
      end
      if (cmd.fin_out) begin
        hv <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      hbyte  <= new_byte;
      hcount <= new_count;
    end
    if ((cmd.emit && hv) || cmd.fin_out) begin
      out_byte     <= hbyte;
      repeat_count <= hcount;
      last         <= cmd.fin_out;
    end
  end

  // a result is never produced past the cap or into a busy output
  a_emit_cap: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!sts.res_full && sts.emit_ok))
    else $error("result emitted past cap or into busy output");

  // moving the held word out always fills the output register
  a_emit_moves: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && hv) |=> (out_valid && !last))
    else $error("held word lost on emit");

  // range is never left at zero after the fix step
  a_fix_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.fix |=> (range != 32'd0))
    else $error("range zero after fix");

  // pending count never falls to zero between shifts
  a_pending_nonzero: assert property (@(posedge clk) disable iff (rst)
    pending != 32'd0)
    else $error("pending count zero");

endmodule

`default_nettype wire

// File: rtl/core/rcel_ctrl.sv
`default_nettype none

module rcel_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [2:0]        opcode,
  input  wire rcel_pkg::rc_sts_t sts,
  output rcel_pkg::rc_cmd_t      cmd
);

  typedef enum logic [16:0] {
    S_IDLE    = 17'h00001,
    S_DIV     = 17'h00002,
    S_FMUL1   = 17'h00004,
    S_FADD    = 17'h00008,
    S_FMUL2   = 17'h00010,
    S_FSET    = 17'h00020,
    S_BSH     = 17'h00040,
    S_BMUL    = 17'h00080,
    S_BAPP    = 17'h00100,
    S_RN_CHK  = 17'h00200,
    S_DB_LOOP = 17'h00400,
    S_DB_CHK  = 17'h00800,
    S_LS_R1   = 17'h01000,
    S_LS_R2   = 17'h02000,
    S_LS_UPD  = 17'h04000,
    S_FIX     = 17'h08000,
    S_FIN     = 17'h10000
  } state_t;

  // where a low shift returns to
  typedef enum logic [1:0] {
    MODE_RENORM,
    MODE_DIRECT,
    MODE_FLUSH
  } mode_t;

  state_t     state;
  state_t     state_next;
  mode_t      mode;
  mode_t      mode_next;
  logic [2:0] nsh;
  logic [2:0] nsh_next;

  assign in_ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode  <= MODE_RENORM;
      nsh   <= '0;
    end else begin
      state <= state_next;
      mode  <= mode_next;
      nsh   <= nsh_next;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    mode_next  = mode;
    nsh_next   = nsh;
    cmd        = '0;
    cmd.mul_sel = rcel_pkg::MUL_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          nsh_next = '0;
          case (opcode)
            rcel_pkg::OP_INIT: cmd.init = 1'b1;
            rcel_pkg::OP_FREQ: begin
              cmd.div_start = 1'b1;
              mode_next     = MODE_RENORM;
              state_next    = S_DIV;
            end
            rcel_pkg::OP_BINARY: begin
              mode_next  = MODE_RENORM;
              state_next = S_BSH;
            end
            rcel_pkg::OP_DIRECT: begin
              mode_next  = MODE_DIRECT;
              state_next = S_DB_LOOP;
            end
            rcel_pkg::OP_FLUSH: begin
              mode_next  = MODE_FLUSH;
              state_next = S_LS_R1;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_next = S_FMUL1;
        end
      end
      S_FMUL1: begin
        cmd.mul_sel = rcel_pkg::MUL_START_Q;
        state_next  = S_FADD;
      end
      S_FADD: begin
        cmd.add_low = 1'b1;
        state_next  = S_FMUL2;
      end
      S_FMUL2: begin
        cmd.mul_sel = rcel_pkg::MUL_Q_SIZE;
        state_next  = S_FSET;
      end
      S_FSET: begin
        cmd.set_range = 1'b1;
        state_next    = S_RN_CHK;
      end
      S_BSH: begin
        cmd.shift_tmp = 1'b1;
        state_next    = S_BMUL;
      end
      S_BMUL: begin
        cmd.mul_sel = rcel_pkg::MUL_TMP_PZ;
        state_next  = S_BAPP;
      end
      S_BAPP: begin
        cmd.bin_apply = 1'b1;
        state_next    = S_RN_CHK;
      end
      S_RN_CHK: begin
        if (sts.range_lt_top && nsh != rcel_pkg::RENORM_MAX) begin
          nsh_next   = nsh + 3'd1;
          state_next = S_LS_R1;
        end else begin
          state_next = S_FIX;
        end
      end
      S_DB_LOOP: begin
        if (sts.cnt_zero) begin
          state_next = S_FIX;
        end else begin
          cmd.db_step = 1'b1;
          state_next  = S_DB_CHK;
        end
      end
      S_DB_CHK: begin
        state_next = sts.range_lt_top ? S_LS_R1 : S_DB_LOOP;
      end
      // cached byte plus carry
      S_LS_R1: begin
        if (!sts.release_byte || sts.res_full) begin
          state_next = S_LS_R2;
        end else if (sts.emit_ok) begin
          cmd.emit   = 1'b1;
          state_next = S_LS_R2;
        end
      end
      // run of 0xFF plus carry
      S_LS_R2: begin
        if (!(sts.release_byte && sts.pend_gt1) || sts.res_full) begin
          state_next = S_LS_UPD;
        end else if (sts.emit_ok) begin
          cmd.emit        = 1'b1;
          cmd.emit_second = 1'b1;
          state_next      = S_LS_UPD;
        end
      end
      S_LS_UPD: begin
        cmd.ls_update = 1'b1;
        cmd.ls_range  = mode != MODE_FLUSH;
        case (mode)
          MODE_RENORM: state_next = S_RN_CHK;
          MODE_DIRECT: state_next = S_DB_LOOP;
          MODE_FLUSH: begin
            if (nsh == rcel_pkg::FLUSH_LAST) begin
              state_next = S_FIN;
            end else begin
              nsh_next   = nsh + 3'd1;
              state_next = S_LS_R1;
            end
          end
          default: state_next = S_FIN;
        endcase
      end
      S_FIX: begin
        cmd.fix    = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!sts.held_valid) begin
          state_next = S_IDLE;
        end else if (sts.emit_ok) begin
          cmd.fin_out = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/range_encoder_lzma.sv
// sequence after acceptance: init and undefined opcodes return straight to idle; binary and
// frequency encode (32-step serial divider) then renormalize with low shifts; direct bits
// step once per bit with low shifts as needed; flush runs its low shifts and final output
// throughput: one word at a time; a full output register adds stall cycles
// reset: synchronous, restores low 0, range all ones, cache 0, pending count 1
`default_nettype none

module range_encoder_lzma (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  opcode,
  input  wire logic [31:0] freq_start,
  input  wire logic [31:0] freq_size,
  input  wire logic [31:0] freq_total,
  input  wire logic [31:0] prob_zero,
  input  wire logic [4:0]  prob_bits,
  input  wire logic        bit_value,
  input  wire logic [31:0] raw_value,
  input  wire logic [5:0]  raw_count,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic [31:0]      repeat_count,
  output logic             last
);

  rcel_pkg::rc_cmd_t cmd;
  rcel_pkg::rc_sts_t sts;

  rcel_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .opcode   (opcode),
    .sts      (sts),
    .cmd      (cmd)
  );

  rcel_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .freq_start   (freq_start),
    .freq_size    (freq_size),
    .freq_total   (freq_total),
    .prob_zero    (prob_zero),
    .prob_bits    (prob_bits),
    .bit_value    (bit_value),
    .raw_value    (raw_value),
    .raw_count    (raw_count),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .repeat_count (repeat_count),
    .last         (last)
  );

endmodule

`default_nettype wire
